// ----- rtl/pfr_pkg.sv -----
`default_nettype none

package pfr_pkg;

  // Default geometry
  localparam int unsigned DEF_CHUNK_SIZE      = 256;
  localparam int unsigned DEF_FRAME_MEM_BYTES = 65536;

  // Fixed field widths
  localparam int unsigned BLOCK_W   = 16;
  localparam int unsigned PIX_W     = 12;
  localparam int unsigned CHIDX_W   = 16;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned EXP_W     = 16;
  localparam int unsigned RADDR_W   = 16;
  localparam int unsigned RECV_W    = 9;

  // Frame size arithmetic: width * height, times up to three bytes per pixel
  localparam int unsigned PROD_W    = 2 * PIX_W;
  localparam int unsigned SIZE_W    = PROD_W + 2;
  localparam int unsigned BPP_RGB   = 3;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned OUT_USER_W = 1;

  // Output queue
  localparam int unsigned OUT_Q_DEPTH = 3;
  localparam int unsigned OUT_Q_CNT_W = 2;

  typedef enum logic [1:0] {
    CMD_LEADER  = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_TRAILER = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic                   complete;
    logic [BLOCK_W-1:0]     block;
    logic [PIX_W-1:0]       width;
    logic [PIX_W-1:0]       height;
    logic                   format;
    logic [EXP_W-1:0]       expected;
    logic [RECV_W-1:0]      received;
    logic [BYTE_W-1:0]      read_byte;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/pfr_ram.sv -----
`default_nettype none

module pfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [$clog2(Depth)-1:0]  waddr_i,
  input  wire  [Width-1:0]          wdata_i,
  input  wire                       re_i,
  input  wire  [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pfr_out_fifo.sv -----
`default_nettype none

module pfr_out_fifo (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              push_i,
  input  pfr_pkg::res_t                    push_data_i,
  output logic                             valid_o,
  input  wire                              ready_i,
  output pfr_pkg::res_t                    data_o,
  output logic [pfr_pkg::OUT_Q_CNT_W-1:0]  count_o
);

  import pfr_pkg::*;

  res_t                   slot_q [OUT_Q_DEPTH];
  logic [OUT_Q_CNT_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_Q_CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_Q_CNT_W-1:0] cnt_q, cnt_d;
  logic                   pop;

  function automatic logic [OUT_Q_CNT_W-1:0] ptr_inc(input logic [OUT_Q_CNT_W-1:0] p);
    if (p == OUT_Q_CNT_W'(OUT_Q_DEPTH - 1)) begin
      return '0;
    end
    return p + OUT_Q_CNT_W'(1);
  endfunction

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + OUT_Q_CNT_W'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - OUT_Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/packet_frame_reassembler.sv -----
`default_nettype none

// Channel     Dir  Signals                          Content
// s_axis      in   tvalid/tready/tdata[111:0]/tuser  leader, payload byte, trailer, read
// m_axis      out  tvalid/tready/tdata[79:0]/tuser   frame report or read data
//
// One item per cycle in while s_axis_tready is high, one result per cycle out
// while m_axis_tready is high. Reads and reports pass the result stage, beside
// the frame buffer's registered read port, then the output queue. Payload writes
// and read lookups both use the buffer at the accepting edge, so no forwarding is
// needed. s_axis_tready drops only when three results are pending.
// Reset clears frame state and the chunk map; buffer contents stay unknown.
// CHUNK_SIZE must be a power of two.

module packet_frame_reassembler #(
  parameter int unsigned CHUNK_SIZE      = pfr_pkg::DEF_CHUNK_SIZE,
  parameter int unsigned FRAME_MEM_BYTES = pfr_pkg::DEF_FRAME_MEM_BYTES
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // tdata, low bit up: block_number, width_px, height_px, pix_format,
  // chunk_index, byte_pos, data_byte, expected_chunks, read_addr, zero pad
  input  wire  [pfr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: cmd
  input  wire  [pfr_pkg::IN_USER_W-1:0]    s_axis_tuser,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, low bit up: frame_complete, report_block, report_width, report_height,
  // report_format, chunks_expected, chunks_received, read_byte, zero pad
  output logic [pfr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: result_kind
  output logic [pfr_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready
);

  import pfr_pkg::*;

  localparam int unsigned ChunkW    = $clog2(CHUNK_SIZE);
  localparam int unsigned AddrW     = $clog2(FRAME_MEM_BYTES);
  localparam int unsigned NumChunks = (FRAME_MEM_BYTES + CHUNK_SIZE - 1) / CHUNK_SIZE;
  localparam int unsigned ChIdxW    = (NumChunks > 1) ? $clog2(NumChunks) : 1;
  localparam int unsigned SeenW     = $clog2(NumChunks + 1);
  localparam int unsigned FbW       = $clog2(FRAME_MEM_BYTES + 1);
  localparam int unsigned FullW     = CHIDX_W + ChunkW;
  localparam int unsigned CmpW      = (FullW > FbW) ? FullW : FbW;
  localparam int unsigned SatW      = (SIZE_W > FbW) ? SIZE_W : FbW;
  localparam int unsigned CntW      = (SeenW > EXP_W) ? SeenW : EXP_W;

  // ---------------------------------------------------------------- input
  cmd_e               in_cmd;
  logic [BLOCK_W-1:0] in_block;
  logic [PIX_W-1:0]   in_width;
  logic [PIX_W-1:0]   in_height;
  logic               in_fmt;
  logic [CHIDX_W-1:0] in_chunk;
  logic [POS_W-1:0]   in_pos;
  logic [BYTE_W-1:0]  in_data;
  logic [EXP_W-1:0]   in_exp;
  logic [RADDR_W-1:0] in_raddr;
  logic               in_acc;

  assign in_cmd    = cmd_e'(s_axis_tuser);
  assign in_block  = s_axis_tdata[15:0];
  assign in_width  = s_axis_tdata[27:16];
  assign in_height = s_axis_tdata[39:28];
  assign in_fmt    = s_axis_tdata[40];
  assign in_chunk  = s_axis_tdata[56:41];
  assign in_pos    = s_axis_tdata[64:57];
  assign in_data   = s_axis_tdata[72:65];
  assign in_exp    = s_axis_tdata[88:73];
  assign in_raddr  = s_axis_tdata[104:89];

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------- frame state
  logic                 active_q, active_d;
  logic [BLOCK_W-1:0]   block_q, block_d;
  logic [PIX_W-1:0]     width_q, width_d;
  logic [PIX_W-1:0]     height_q, height_d;
  logic                 fmt_q, fmt_d;
  logic [FbW-1:0]       fbytes_q, fbytes_d;
  logic [NumChunks-1:0] seen_q, seen_d;      // received-chunk map
  logic [SeenW-1:0]     seen_cnt_q, seen_cnt_d;
  logic                 pkt_acc_q, pkt_acc_d;

  // leader: frame byte size, saturated at the buffer size
  logic [PROD_W-1:0] px_prod;
  logic [SIZE_W-1:0] size_raw;
  logic              size_sat;

  assign px_prod  = {{PIX_W{1'b0}}, in_width} * {{PIX_W{1'b0}}, in_height};
  assign size_raw = in_fmt ? SIZE_W'(px_prod) * SIZE_W'(BPP_RGB) : SIZE_W'(px_prod);
  assign size_sat = SatW'(size_raw) > SatW'(FRAME_MEM_BYTES);

  // payload address and chunk checks
  logic [CmpW-1:0]   pay_ch_full;
  logic [CmpW-1:0]   pay_base;
  logic [CmpW-1:0]   pay_addr;
  logic [ChIdxW-1:0] pay_idx;
  logic              pay_match;
  logic              pay_start_ok;
  logic              pay_acc_eff;
  logic              pay_we;

  assign pay_ch_full  = CmpW'(in_chunk);
  assign pay_base     = pay_ch_full << ChunkW;
  assign pay_addr     = pay_base + CmpW'(in_pos);
  assign pay_idx      = pay_ch_full[ChIdxW-1:0];
  assign pay_match    = active_q && (in_block == block_q);
  // base inside the frame also bounds the chunk index to the map
  assign pay_start_ok = (pay_base < CmpW'(fbytes_q)) && !seen_q[pay_idx];
  assign pay_acc_eff  = (in_pos == '0) ? pay_start_ok : pkt_acc_q;
  assign pay_we       = in_acc && (in_cmd == CMD_PAYLOAD) && pay_match && pay_acc_eff
                        && (CmpW'(in_pos) < CmpW'(CHUNK_SIZE))
                        && (pay_addr < CmpW'(fbytes_q));

  // read lookup gate
  logic [CmpW-1:0]   rd_full;
  logic [CmpW-1:0]   rd_ch_full;
  logic [ChIdxW-1:0] rd_idx;
  logic              rd_gate;
  logic              rd_en;

  assign rd_full    = CmpW'(in_raddr);
  assign rd_ch_full = rd_full >> ChunkW;
  assign rd_idx     = rd_ch_full[ChIdxW-1:0];
  assign rd_gate    = (rd_full < CmpW'(fbytes_q)) && seen_q[rd_idx];
  assign rd_en      = in_acc && (in_cmd == CMD_READ);

  // trailer report fields
  logic [CntW-1:0] seen_ext;
  logic            frame_complete;

  assign seen_ext       = CntW'(seen_cnt_q);
  assign frame_complete = (seen_ext == CntW'(in_exp));

  always_comb begin
    active_d   = active_q;
    block_d    = block_q;
    width_d    = width_q;
    height_d   = height_q;
    fmt_d      = fmt_q;
    fbytes_d   = fbytes_q;
    seen_d     = seen_q;
    seen_cnt_d = seen_cnt_q;
    pkt_acc_d  = pkt_acc_q;
    if (in_acc) begin
      case (in_cmd)
        CMD_LEADER: begin
          active_d   = 1'b1;
          block_d    = in_block;
          width_d    = in_width;
          height_d   = in_height;
          fmt_d      = in_fmt;
          fbytes_d   = size_sat ? FbW'(FRAME_MEM_BYTES) : FbW'(size_raw);
          seen_d     = '0;
          seen_cnt_d = '0;
          pkt_acc_d  = 1'b0;
        end
        CMD_PAYLOAD: begin
          if (pay_match && (in_pos == '0)) begin
            pkt_acc_d = pay_start_ok;
            if (pay_start_ok) begin
              seen_d[pay_idx] = 1'b1;
              seen_cnt_d      = seen_cnt_q + SeenW'(1);
            end
          end
        end
        CMD_TRAILER: begin
          if (pay_match) begin
            active_d  = 1'b0;
            pkt_acc_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      block_q    <= '0;
      width_q    <= '0;
      height_q   <= '0;
      fmt_q      <= 1'b0;
      fbytes_q   <= '0;
      seen_q     <= '0;
      seen_cnt_q <= '0;
      pkt_acc_q  <= 1'b0;
    end else begin
      active_q   <= active_d;
      block_q    <= block_d;
      width_q    <= width_d;
      height_q   <= height_d;
      fmt_q      <= fmt_d;
      fbytes_q   <= fbytes_d;
      seen_q     <= seen_d;
      seen_cnt_q <= seen_cnt_d;
      pkt_acc_q  <= pkt_acc_d;
    end
  end

  // --------------------------------------------------------- frame buffer
  logic [BYTE_W-1:0] ram_rdata;

  pfr_ram #(
    .Width (BYTE_W),
    .Depth (FRAME_MEM_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_addr[AddrW-1:0]),
    .wdata_i (in_data),
    .re_i    (rd_en),
    .raddr_i (rd_full[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------- result stage (RAM in flight)
  logic s1_valid_q, s1_valid_d;
  logic s1_gate_q;
  res_t s1_res_q;
  res_t s1_res_d;
  logic res_new;

  assign res_new    = rd_en || (in_acc && (in_cmd == CMD_TRAILER) && pay_match);
  assign s1_valid_d = res_new;

  always_comb begin
    s1_res_d = '0;
    if (in_cmd == CMD_READ) begin
      s1_res_d.kind = KIND_READ;
    end else begin
      s1_res_d.kind     = KIND_REPORT;
      s1_res_d.complete = frame_complete;
      s1_res_d.block    = block_q;
      s1_res_d.width    = width_q;
      s1_res_d.height   = height_q;
      s1_res_d.format   = fmt_q;
      s1_res_d.expected = in_exp;
      s1_res_d.received = seen_ext[RECV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_new) begin
      s1_res_q  <= s1_res_d;
      s1_gate_q <= (in_cmd == CMD_READ) && rd_gate;
    end
  end

  // ---------------------------------------------------------- output queue
  res_t                   q_push_data;
  res_t                   q_head;
  logic [OUT_Q_CNT_W-1:0] q_cnt;
  logic [OUT_Q_CNT_W:0]   pending;

  always_comb begin
    q_push_data           = s1_res_q;
    q_push_data.read_byte = s1_gate_q ? ram_rdata : '0;
  end

  pfr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (q_push_data),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (q_head),
    .count_o     (q_cnt)
  );

  // results in flight plus queued must leave a slot for the next item
  assign pending       = {1'b0, q_cnt} + (OUT_Q_CNT_W + 1)'(s1_valid_q);
  assign s_axis_tready = pending < (OUT_Q_CNT_W + 1)'(OUT_Q_DEPTH);

  assign m_axis_tuser = q_head.kind;
  assign m_axis_tdata = {5'b0, q_head.read_byte, q_head.received, q_head.expected,
                         q_head.format, q_head.height, q_head.width, q_head.block,
                         q_head.complete};

endmodule

`default_nettype wire
